// ===== hdl/signal_pending_mask_dispatcher_unit_assert.svh =====
// Assertion macros shared by the checker of the signal dispatcher.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef SIGNAL_PENDING_MASK_DISPATCHER_UNIT_ASSERT_SVH
`define SIGNAL_PENDING_MASK_DISPATCHER_UNIT_ASSERT_SVH
// Same-cycle implication.
`define SPMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("signal dispatcher assertion failed");
// Next-cycle implication.
`define SPMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("signal dispatcher assertion failed");
`endif

// ===== hdl/spmd_pkg.sv =====
// Package of the signal pending mask dispatcher: request and outcome codes,
// controller states, signal constants and the token that travels along the row of cells.
// No dependencies.
package spmd_pkg;

   typedef enum logic [2:0] {
      REQ_RAISE   = 3'd0,
      REQ_CLEAR   = 3'd1,
      REQ_ACTION  = 3'd2,
      REQ_MASK    = 3'd3,
      REQ_DELIVER = 3'd4,
      REQ_RESET   = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      OUT_NONE      = 2'd0,
      OUT_HANDLER   = 2'd1,
      OUT_TERMINATE = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      MASK_BLOCK   = 2'd0,
      MASK_UNBLOCK = 2'd1
   } mask_how_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_HOLD} state_type;

   localparam int SIG_KILL   = 9;
   localparam int SIG_STOP   = 19;
   localparam int SIG_IGN_A  = 17;
   localparam int SIG_IGN_B  = 18;
   localparam int SIG_IGN_C  = 23;
   localparam int SIG_IGN_D  = 28;
   localparam int EXIT_BASE  = 128;
   localparam logic [31:0] HANDLER_DEFAULT = 32'd0;
   localparam logic [31:0] HANDLER_IGNORE  = 32'd1;

   typedef struct packed {
      logic         valid;
      req_code_type req;
      logic [6:0]   sig_num;
      logic         write_enable;
      logic [31:0]  handler_word;
      logic [1:0]   mask_how;
      logic [63:0]  mask_value;
      logic         done;
      logic         status;
      logic [31:0]  old_handler;
      logic [63:0]  old_mask;
      outcome_type  outcome;
      logic [6:0]   delivered_signal;
      logic [31:0]  handler_address;
      logic [7:0]   exit_code;
   } token_type;

endpackage

// ===== hdl/spmd_cell.sv =====
// One signal cell: pending bit, blocked bit and handler word of one signal.
// It acts on the token passing through and hands it on. Uses spmd_pkg.
module spmd_cell import spmd_pkg::*; #(
   parameter int CELL_SIG = 1
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out
);

   localparam bit UNBLK = (CELL_SIG == SIG_KILL) || (CELL_SIG == SIG_STOP);
   localparam bit IGN   = (CELL_SIG == SIG_IGN_A) || (CELL_SIG == SIG_IGN_B) ||
                          (CELL_SIG == SIG_IGN_C) || (CELL_SIG == SIG_IGN_D);

   logic        pending_ff, pending_in;
   logic        blocked_ff, blocked_in;
   logic [31:0] handler_ff, handler_in;
   token_type   tok_ff, tok_next_in;
   logic        hit;

   assign hit = (tok_in.sig_num == 7'(CELL_SIG));

   always_comb begin
      pending_in  = pending_ff;
      blocked_in  = blocked_ff;
      handler_in  = handler_ff;
      tok_next_in = tok_in;
      if (tok_in.valid) begin
         case (tok_in.req)
            REQ_RAISE: begin
               if (hit) pending_in = 1'b1;
            end
            REQ_CLEAR: begin
               if (hit) pending_in = 1'b0;
            end
            REQ_ACTION: begin
               if (hit && !UNBLK) begin
                  tok_next_in.old_handler = handler_ff;
                  if (tok_in.write_enable) handler_in = tok_in.handler_word;
               end
            end
            REQ_MASK: begin
               tok_next_in.old_mask[CELL_SIG-1] = blocked_ff;
               if (tok_in.write_enable && !UNBLK) begin
                  case (tok_in.mask_how)
                     MASK_BLOCK:   blocked_in = blocked_ff | tok_in.mask_value[CELL_SIG-1];
                     MASK_UNBLOCK: blocked_in = blocked_ff & ~tok_in.mask_value[CELL_SIG-1];
                     default:      blocked_in = tok_in.mask_value[CELL_SIG-1];
                  endcase
               end
            end
            REQ_DELIVER: begin
               if (!tok_in.done && pending_ff && !blocked_ff) begin
                  pending_in = 1'b0;
                  if (UNBLK || (handler_ff == HANDLER_DEFAULT && !IGN)) begin
                     tok_next_in.done             = 1'b1;
                     tok_next_in.outcome          = OUT_TERMINATE;
                     tok_next_in.delivered_signal = 7'(CELL_SIG);
                     tok_next_in.exit_code        = 8'(EXIT_BASE + CELL_SIG);
                  end else if (handler_ff != HANDLER_DEFAULT &&
                               handler_ff != HANDLER_IGNORE) begin
                     tok_next_in.done             = 1'b1;
                     tok_next_in.outcome          = OUT_HANDLER;
                     tok_next_in.delivered_signal = 7'(CELL_SIG);
                     tok_next_in.handler_address  = handler_ff;
                  end
               end
            end
            REQ_RESET: begin
               pending_in = 1'b0;
               blocked_in = 1'b0;
               handler_in = HANDLER_DEFAULT;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         blocked_ff <= 1'b0;
         handler_ff <= HANDLER_DEFAULT;
         tok_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         blocked_ff <= blocked_in;
         handler_ff <= handler_in;
         tok_ff     <= tok_next_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hdl/signal_pending_mask_dispatcher_unit.sv =====
// Top level of the signal pending mask dispatcher: request control and the
// row of signal cells. Depends on spmd_pkg and spmd_cell.
//
// The block keeps the signal state of one task in a row of NUM_SIGNALS
// cells, one per signal, each holding that signal's pending bit, blocked
// bit and handler word. A request is taken only while the block is idle;
// it is turned into a token that moves one cell along the row in every
// cycle, and each cell applies the request to its own signal as the token
// passes. A deliver check therefore sees the signals in rising order and the
// first cell that delivers marks the token as done. When the token leaves the
// last cell, its response is loaded into the output register, or into a
// holding register behind it while the output register is still occupied, and
// the next request can be taken in the cycle after the response has been
// loaded into the output register. A finished response waits in the output
// register while the next request is accepted; while it waits in the
// holding register, no request is taken. Reset clears the controller, the
// response valid flag and all cell state, including every handler word.
module signal_pending_mask_dispatcher_unit import spmd_pkg::*; #(
   parameter int NUM_SIGNALS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata, lowest bit up: sig_num[6:0], write_enable[7], handler_word[39:8],
   // mask_how[41:40], mask_value[105:42], zero fill[111:106]
   input  logic [111:0] req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata, lowest bit up: status[0], old_handler[32:1], old_mask[96:33],
   // delivered_signal[103:97], handler_address[135:104], exit_code[143:136]
   output logic [143:0] rsp_tdata,
   // rsp_tuser: outcome[1:0]
   output logic [1:0]   rsp_tuser
);

   state_type state_ff, state_in;
   token_type chain [0:NUM_SIGNALS];
   token_type launch;
   token_type rsp_ff, rsp_in;
   token_type hold_ff, hold_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, slot_free, load_end, load_hold, keep_end;
   logic [6:0] sig;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign sig       = req_tdata[6:0];

   // The token is built from the request; the status of a bad signal number
   // is settled here, so that no cell matches it.
   always_comb begin
      launch              = '0;
      launch.valid        = accept;
      launch.req          = req_code_type'(req_tuser);
      launch.sig_num      = sig;
      launch.write_enable = req_tdata[7];
      launch.handler_word = req_tdata[39:8];
      launch.mask_how     = req_tdata[41:40];
      launch.mask_value   = req_tdata[105:42];
      case (req_code_type'(req_tuser))
         REQ_RAISE, REQ_CLEAR:
            launch.status = (sig == 7'd0) || (sig > 7'(NUM_SIGNALS));
         REQ_ACTION:
            launch.status = (sig == 7'd0) || (sig > 7'(NUM_SIGNALS)) ||
                            (sig == 7'(SIG_KILL)) || (sig == 7'(SIG_STOP));
         default: launch.status = 1'b0;
      endcase
   end

   assign chain[0] = launch;

   for (genvar i = 0; i < NUM_SIGNALS; i++) begin : g_cell
      spmd_cell #(.CELL_SIG(i + 1)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SCAN;
         ST_SCAN: begin
            if (chain[NUM_SIGNALS].valid) state_in = slot_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller.
   always_comb begin
      req_tready = 1'b0;
      load_end   = 1'b0;
      keep_end   = 1'b0;
      load_hold  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: begin
            load_end = chain[NUM_SIGNALS].valid && slot_free;
            keep_end = chain[NUM_SIGNALS].valid && !slot_free;
         end
         ST_HOLD: load_hold = slot_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_end) begin
         rsp_in       = chain[NUM_SIGNALS];
         rsp_valid_in = 1'b1;
      end else if (load_hold) begin
         rsp_in       = hold_ff;
         rsp_valid_in = 1'b1;
      end
      if (keep_end) hold_in = chain[NUM_SIGNALS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.exit_code, rsp_ff.handler_address, rsp_ff.delivered_signal,
                        rsp_ff.old_mask, rsp_ff.old_handler, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.outcome;

endmodule

// ===== hdl/spmd_checker.sv =====
// Port checker of the signal dispatcher and its bind to the top level.
// Uses spmd_pkg and the assertion macro header.
`include "signal_pending_mask_dispatcher_unit_assert.svh"

module spmd_checker import spmd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [111:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A waiting response stays offered.
   `SPMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Requests are worked one at a time.
   `SPMD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   // A termination reports 128 plus the delivered signal.
   `SPMD_ASSERT_IMP(a_exit_code, clock, reset,
      rsp_tvalid && (rsp_tuser == OUT_TERMINATE),
      rsp_tdata[143:136] == {1'b1, rsp_tdata[103:97]})
   // Nothing delivered leaves the delivery fields at zero.
   `SPMD_ASSERT_IMP(a_none_zero, clock, reset,
      rsp_tvalid && (rsp_tuser == OUT_NONE), rsp_tdata[143:97] == 47'd0)

endmodule

bind signal_pending_mask_dispatcher_unit spmd_checker u_spmd_checker (.*);
